### hw/rtl/uart_receiver_defines.svh
// uart_receiver_defines.svh: assertion macros for the serial receiver checker
// relies on signals named clock and reset in the module that uses the macros
`ifndef UART_RECEIVER_DEFINES_SVH
`define UART_RECEIVER_DEFINES_SVH

// same-cycle implication, switched off while reset is high
`define URX_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, switched off while reset is high
`define URX_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// same-cycle implication that also holds around reset
`define URX_ASSERT_RST(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |-> (cons)) else $error(msg);

`endif

### hw/rtl/urx_pkg.sv
// urx_pkg: shared types and constants of the serial receiver
// no dependencies; used by every module of the receiver
`timescale 1ns / 1ps

package urx_pkg;

   localparam int BYTE_W           = 8;
   localparam int LEN_W            = 16;
   localparam int COUNT_W          = 17;
   localparam int QUEUE_DEPTH      = 2;
   localparam int QUEUE_PTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam logic [LEN_W-1:0] BIT_LENGTH_RESET = 16'd434;

   typedef enum logic {
      RX_IDLE,
      RX_DATA
   } urx_state_type;

   // one processed tick, handed from the front to the back
   typedef struct packed {
      logic              finished;
      logic [BYTE_W-1:0] word;
      logic              ready;
   } urx_entry_type;

endpackage

### hw/rtl/urx_front.sv
// urx_front: line synchronizer, bit timing and shift register of the receiver
// depends on urx_pkg; pushes one urx_entry_type per accepted tick
`timescale 1ns / 1ps

module urx_front import urx_pkg::*; #(
   parameter int DATA_BITS   = 8,
   parameter int SYNC_STAGES = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_rx_line,
   input  logic             req_out_ready,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [LEN_W-1:0] csr_bit_length,
   input  logic             q_full,
   output logic             q_push,
   output urx_entry_type    q_entry
);

   localparam int IDX_W = (DATA_BITS > 1) ? $clog2(DATA_BITS) : 1;

   logic                 accept;
   logic                 line_s;
   urx_state_type        state_ff, state_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [DATA_BITS-1:0] shift_ff, shift_in;
   logic [LEN_W-1:0]     bit_length_ff;
   logic [COUNT_W:0]     triple;
   logic [COUNT_W-1:0]   load_half;
   logic [COUNT_W-1:0]   load_bit;
   logic                 finished;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // synchronizer, advances once per tick
   if (SYNC_STAGES == 0) begin : g_nosync
      assign line_s = req_rx_line;
   end else begin : g_sync
      logic [SYNC_STAGES-1:0] sync_ff, sync_in;
      if (SYNC_STAGES == 1) begin : g_one
         assign sync_in = req_rx_line;
      end else begin : g_many
         assign sync_in = {sync_ff[SYNC_STAGES-2:0], req_rx_line};
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            sync_ff <= '1;
         end else if (accept) begin
            sync_ff <= sync_in;
         end
      end
      assign line_s = sync_ff[SYNC_STAGES-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_length_ff <= BIT_LENGTH_RESET;
      end else if (csr_valid && csr_ready) begin
         bit_length_ff <= csr_bit_length;
      end
   end

   // countdown reloads, 17-bit wraparound
   assign triple    = {2'b00, bit_length_ff} + {1'b0, bit_length_ff, 1'b0};
   assign load_half = triple[COUNT_W:1] - COUNT_W'(1);
   assign load_bit  = {1'b0, bit_length_ff} - COUNT_W'(1);

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      idx_in   = idx_ff;
      shift_in = shift_ff;
      finished = 1'b0;
      unique case (state_ff)
         RX_IDLE: begin
            if (count_ff == '0) begin
               if (!line_s) begin
                  state_in = RX_DATA;
                  count_in = load_half;
               end
            end else begin
               count_in = count_ff - COUNT_W'(1);
            end
         end
         RX_DATA: begin
            if (count_ff == '0) begin
               shift_in = {line_s, shift_ff[DATA_BITS-1:1]};
               count_in = load_bit;
               if (idx_ff == IDX_W'(DATA_BITS - 1)) begin
                  idx_in   = '0;
                  finished = 1'b1;
                  state_in = RX_IDLE;
               end else begin
                  idx_in = idx_ff + IDX_W'(1);
               end
            end else begin
               count_in = count_ff - COUNT_W'(1);
            end
         end
         default: begin
            state_in = RX_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= RX_IDLE;
         count_ff <= '0;
         idx_ff   <= '0;
      end else if (accept) begin
         state_ff <= state_in;
         count_ff <= count_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         shift_ff <= shift_in;
      end
   end

   assign q_push           = accept;
   assign q_entry.finished = finished;
   assign q_entry.word     = BYTE_W'(shift_in);
   assign q_entry.ready    = req_out_ready;

endmodule

### hw/rtl/urx_queue.sv
// urx_queue: short flop queue between the front and the back
// depends on urx_pkg for the entry type and depth
`timescale 1ns / 1ps

module urx_queue import urx_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  urx_entry_type push_entry,
   output logic          full,
   output logic          not_empty,
   input  logic          pop,
   output urx_entry_type pop_entry
);

   urx_entry_type          slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : wr_ptr_ff + QUEUE_PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : rd_ptr_ff + QUEUE_PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QUEUE_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

### hw/rtl/urx_back.sv
// urx_back: one-entry byte holder and registered result stage
// depends on urx_pkg; takes entries from urx_queue
`timescale 1ns / 1ps

module urx_back import urx_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_not_empty,
   input  urx_entry_type     q_entry,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_out_valid,
   output logic [BYTE_W-1:0] rsp_out_data
);

   logic              holder_full_ff, holder_full_in;
   logic [BYTE_W-1:0] holder_word_ff, holder_word_in;
   logic              rsp_valid_ff;
   logic              out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0] out_data_ff, out_data_in;

   assign q_pop = q_not_empty && (!rsp_valid_ff || rsp_ready);

   // a byte finishing while the holder is full is dropped
   always_comb begin
      out_valid_in   = holder_full_ff || q_entry.finished;
      holder_word_in = holder_full_ff ? holder_word_ff : q_entry.word;
      out_data_in    = out_valid_in ? holder_word_in : '0;
      holder_full_in = out_valid_in && !q_entry.ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         holder_full_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (q_pop) begin
            holder_full_ff <= holder_full_in;
         end
         if (q_pop) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         holder_word_ff <= holder_word_in;
         out_valid_ff   <= out_valid_in;
         out_data_ff    <= out_data_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_valid = out_valid_ff;
   assign rsp_out_data  = out_data_ff;

endmodule

### hw/rtl/uart_receiver.sv
// an accepted tick is queued; the back registers its result when it pops the entry
// throughput: one tick per cycle while the queue is not full; the back takes one
//   queue entry per cycle while the result stage is empty or its result is taken
// reset (synchronous, active high): line synchronizer to ones, bit timer and
//   holder cleared, bit length back to 434, queue and result stage empty
`timescale 1ns / 1ps

// uart_receiver: top level of the serial byte receiver
// depends on urx_pkg, urx_front, urx_queue and urx_back
module uart_receiver import urx_pkg::*; #(
   parameter int DATA_BITS   = 8,
   parameter int SYNC_STAGES = 2
) (
   input  logic              clock,
   input  logic              reset,
   // tick channel: one item per serial clock tick
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_rx_line,
   input  logic              req_out_ready,
   // result channel: one item per tick
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_out_valid,
   output logic [BYTE_W-1:0] rsp_out_data,
   // bit length register write
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [LEN_W-1:0]  csr_bit_length
);

   // front to queue
   logic          q_push;
   logic          q_full;
   urx_entry_type q_push_entry;
   // queue to back
   logic          q_pop;
   logic          q_not_empty;
   urx_entry_type q_pop_entry;

   // front: synchronizer, start detect, mid-bit sampling, shift register
   urx_front #(
      .DATA_BITS   (DATA_BITS),
      .SYNC_STAGES (SYNC_STAGES)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_rx_line    (req_rx_line),
      .req_out_ready  (req_out_ready),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_bit_length (csr_bit_length),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_entry        (q_push_entry)
   );

   // short queue so the front keeps running while a result waits
   urx_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_push_entry),
      .full       (q_full),
      .not_empty  (q_not_empty),
      .pop        (q_pop),
      .pop_entry  (q_pop_entry)
   );

   // back: byte holder with consumer handshake, registered result
   urx_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_not_empty   (q_not_empty),
      .q_entry       (q_pop_entry),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_valid (rsp_out_valid),
      .rsp_out_data  (rsp_out_data)
   );

endmodule

### hw/rtl/urx_checker.sv
// urx_checker: port-level checks of the serial receiver, bound to the top level
// depends on urx_pkg and the macros in uart_receiver_defines.svh
`timescale 1ns / 1ps
`include "uart_receiver_defines.svh"

module urx_checker import urx_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic              rsp_out_valid,
   input logic [BYTE_W-1:0] rsp_out_data
);

   // stalled result holds its payload
   `URX_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_out_valid) && $stable(rsp_out_data), "result changed while stalled")

   // no byte presented means the data field is zero
   `URX_ASSERT_IMP(a_null_data, rsp_valid && !rsp_out_valid,
      rsp_out_data == '0, "data nonzero without a byte")

   // with the result stage drained the queue has room
   `URX_ASSERT_IMP(a_drained_ready, !rsp_valid, req_ready, "tick refused with empty output")

   // nothing pending right after reset
   `URX_ASSERT_RST(a_reset_empty, $past(reset), !rsp_valid, "result pending after reset")

endmodule

bind uart_receiver urx_checker u_chk (.*);

### bench/tb.sv
`timescale 1ns / 1ps
// tb: self-checking bench for uart_receiver, serial frames in, per-tick results out
// depends on urx_pkg and uart_receiver; a tick-level decoder predicts every result
module tb;
   import urx_pkg::*;

   localparam int CLOCK_HALF   = 5;
   localparam int RESET_CYCLES = 12;
   localparam int SETTLE       = 6;       // leave some margin after the last result
   localparam int HOLD_CYCLES  = 300;     // long receiver hold-off
   localparam int CYCLE_LIMIT  = 600_000;
   localparam int LINE_LOW     = 0;
   localparam int LINE_HIGH    = 1;
   localparam int LINE_NOISE   = 2;       // random level on every tick

   // one serial clock tick as driven into the block
   typedef struct packed {
      logic rx_line;
      logic out_ready;
   } line_tick_t;

   // what the block shows for one tick
   typedef struct packed {
      logic              out_valid;
      logic [BYTE_W-1:0] out_data;
   } rx_result_t;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic              req_rx_line = 1'b1;
   logic              req_out_ready = 1'b0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic              rsp_out_valid;
   logic [BYTE_W-1:0] rsp_out_data;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [LEN_W-1:0]  csr_bit_length = BIT_LENGTH_RESET;

   // ticks waiting to be offered and outputs the decoder says are due
   line_tick_t line_ticks[$];
   rx_result_t pending_outputs[$];

   // idling controls, set per stage by the stimulus
   int gap_pct   = 0;
   int stall_pct = 0;
   logic hold_off_pending = 1'b0;
   int hold_left = 0;

   int error_count  = 0;
   int queued_total = 0;
   int unsigned cycle_count = 0;

   // decoder state, mirrors the receiver
   logic [LEN_W-1:0]   model_bit_length;
   logic [1:0]         line_sync;         // [0] first stage, [1] sampled stage
   logic [COUNT_W-1:0] countdown;
   logic               rx_idle;
   logic [BYTE_W-1:0]  shift_word;
   logic [2:0]         bit_idx;
   logic               holder_full;
   logic [BYTE_W-1:0]  holder_word;

   uart_receiver #(
      .DATA_BITS   (8),
      .SYNC_STAGES (2)
   ) DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_rx_line    (req_rx_line),
      .req_out_ready  (req_out_ready),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_valid  (rsp_out_valid),
      .rsp_out_data   (rsp_out_data),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_bit_length (csr_bit_length)
   );

   initial begin
      forever #CLOCK_HALF clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   function automatic void reset_decoder();
      model_bit_length = BIT_LENGTH_RESET;
      line_sync        = 2'b11;
      countdown        = '0;
      rx_idle          = 1'b1;
      shift_word       = '0;
      bit_idx          = '0;
      holder_full      = 1'b0;
      holder_word      = '0;
   endfunction

   // advance the decoder by one tick and return what the block must show
   function automatic rx_result_t decode_tick(input line_tick_t t);
      logic       sampled;
      logic       word_done;
      rx_result_t r;
      sampled   = line_sync[1];
      line_sync = {line_sync[0], t.rx_line};
      word_done = 1'b0;
      if (rx_idle) begin
         if (countdown == '0) begin
            // low level while idle starts a frame, wait to mid first data bit
            if (!sampled) begin
               rx_idle   = 1'b0;
               countdown = COUNT_W'((32'(model_bit_length) * 3) / 2 - 1);
            end
         end else begin
            countdown = countdown - 1'b1;
         end
      end else if (countdown == '0) begin
         // sample point: shift in at the top so the first bit lands in the lsb
         shift_word = {sampled, shift_word[BYTE_W-1:1]};
         if (bit_idx == 3'(BYTE_W - 1)) begin
            word_done = 1'b1;
            rx_idle   = 1'b1;
            bit_idx   = '0;
         end else begin
            bit_idx = bit_idx + 1'b1;
         end
         // one bit time more: mid-bit spacing, or the stop bit after the last
         countdown = COUNT_W'(32'(model_bit_length) - 1);
      end else begin
         countdown = countdown - 1'b1;
      end
      // a word finishing into a full holder is lost
      r.out_valid = holder_full;
      r.out_data  = holder_word;
      if (!holder_full && word_done) begin
         r.out_valid = 1'b1;
         r.out_data  = shift_word;
      end
      holder_full = r.out_valid && !t.out_ready;
      holder_word = r.out_data;
      if (!r.out_valid)
         r.out_data = '0;
      return r;
   endfunction

   task automatic queue_ticks(input int level, input int count, input int ready_pct);
      line_tick_t t;
      repeat (count) begin
         t.rx_line   = (level == LINE_NOISE) ? 1'($urandom) : level[0];
         t.out_ready = ($urandom_range(99) < ready_pct);
         line_ticks.push_back(t);
      end
      queued_total += count;
   endtask

   // start bit, nbits data bits lsb first, then stop_ticks of high line
   task automatic queue_frame(input logic [BYTE_W-1:0] data, input int nbits, input int bl,
                              input int stop_ticks, input int ready_pct);
      queue_ticks(LINE_LOW, bl, ready_pct);
      for (int i = 0; i < nbits; i++)
         queue_ticks(data[i] ? LINE_HIGH : LINE_LOW, bl, ready_pct);
      queue_ticks(LINE_HIGH, stop_ticks, ready_pct);
   endtask

   // sender pause: nothing queued, nothing offered, every output seen
   task automatic wait_until_drained();
      while (line_ticks.size() != 0 || req_valid || pending_outputs.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // bit length write, only called with the block drained
   task automatic write_bit_length(input logic [LEN_W-1:0] value);
      csr_valid      <= 1'b1;
      csr_bit_length <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      model_bit_length = value;
   endtask

   // driver: offers ticks, keeps valid and payload until taken
   always @(posedge clock) begin
      line_tick_t t;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (line_ticks.size() != 0 && $urandom_range(99) >= gap_pct) begin
            t = line_ticks.pop_front();
            req_valid     <= 1'b1;
            req_rx_line   <= t.rx_line;
            req_out_ready <= t.out_ready;
            // order is kept and writes happen only when drained
            pending_outputs.push_back(decode_tick(t));
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor: checks each taken result, drives ready with stalls and hold-offs
   always @(posedge clock) begin
      rx_result_t due;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_outputs.size() == 0) begin
               $error("result item with nothing due: out_valid %0b out_data %02h",
                      rsp_out_valid, rsp_out_data);
               error_count++;
            end else begin
               due = pending_outputs.pop_front();
               if (rsp_out_valid !== due.out_valid) begin
                  $error("out_valid: expected %0b, got %0b", due.out_valid, rsp_out_valid);
                  error_count++;
               end
               if (rsp_out_data !== due.out_data) begin
                  $error("out_data: expected %02h, got %02h", due.out_data, rsp_out_data);
                  error_count++;
               end
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (hold_off_pending) begin
            // long hold-off so the block backs up onto its input
            hold_off_pending <= 1'b0;
            hold_left = HOLD_CYCLES;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // stimulus
   initial begin
      int bl;
      int rp;
      int r;
      int nseg;
      int stage_start;
      int stage_frames;
      reset_decoder();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int stage = 0; stage < 3; stage++) begin
         // sender gaps and receiver stalls, swapped, then none
         case (stage)
            0:       begin gap_pct = 29; stall_pct = 62; end
            1:       begin gap_pct = 62; stall_pct = 29; end
            default: begin gap_pct = 0;  stall_pct = 0;  end
         endcase

         if (stage == 0) begin
            // reset bit length: idle line only, a whole frame takes thousands of ticks
            queue_ticks(LINE_HIGH, 40, 100);
            wait_until_drained();

            // shortest legal bit: data extremes and single bits
            write_bit_length(16'd2);
            queue_ticks(LINE_HIGH, 6, 100);
            queue_frame(8'h00, 8, 2, 2, 100);
            queue_frame(8'hFF, 8, 2, 2, 100);
            queue_frame(8'h01, 8, 2, 2, 100);
            queue_frame(8'h80, 8, 2, 2, 100);
            queue_frame(8'h5A, 8, 2, 4, 100);
            // holder left full: second word dropped, then ready clears it
            queue_frame(8'h3C, 8, 2, 2, 0);
            queue_frame(8'hC3, 8, 2, 2, 0);
            queue_ticks(LINE_HIGH, 4, 0);
            queue_ticks(LINE_HIGH, 3, 100);
            // stop bit low, next frame straight after, unchecked stop
            queue_frame(8'h96, 8, 2, 0, 100);
            queue_ticks(LINE_LOW, 2, 100);
            queue_frame(8'h69, 8, 2, 2, 100);
            // one-tick glitch still starts a frame, no filter
            queue_ticks(LINE_LOW, 1, 100);
            queue_ticks(LINE_HIGH, 30, 100);
            wait_until_drained();

            // below range: both loads come out as zero
            write_bit_length(16'd1);
            queue_frame(8'h6B, 8, 1, 2, 100);
            queue_frame(8'h94, 8, 1, 3, 50);
            queue_ticks(LINE_HIGH, 6, 100);
            wait_until_drained();

            // widest bit: idle line only, a frame would run far too long
            write_bit_length(16'hFFFF);
            queue_ticks(LINE_HIGH, 30, 50);
            wait_until_drained();
         end

         if (stage == 2) begin
            // receiver holds off while the sender keeps offering ticks
            write_bit_length(16'd3);
            hold_off_pending = 1'b1;
            for (int i = 0; i < 10; i++)
               queue_frame(8'($urandom), 8, 3, 3, 100);
            wait_until_drained();
         end

         // random phases: mostly clean frames, some noise and broken frames
         stage_start  = queued_total;
         stage_frames = 0;
         while (queued_total - stage_start < 200 || stage_frames < 2) begin
            r = $urandom_range(99);
            if (r < 70)
               bl = $urandom_range(2, 6);
            else if (r < 92)
               bl = $urandom_range(7, 24);
            else
               bl = $urandom_range(25, 48);
            write_bit_length(LEN_W'(bl));
            nseg = $urandom_range(1, 3);
            repeat (nseg) begin
               case ($urandom_range(3))
                  0:       rp = 0;
                  1:       rp = 10;
                  2:       rp = 60;
                  default: rp = 100;
               endcase
               r = $urandom_range(99);
               if (r < 75) begin
                  queue_frame(8'($urandom), 8, bl, bl * $urandom_range(1, 3), rp);
                  stage_frames++;
               end else if (r < 85) begin
                  queue_ticks(LINE_NOISE, $urandom_range(1, 3 * bl), rp);
               end else if (r < 93) begin
                  // frame cut short, the rest is sampled from the idle line
                  queue_frame(8'($urandom), $urandom_range(1, 7), bl, 2 * bl, rp);
               end else begin
                  // stop bit low, the low level may start the next frame
                  queue_frame(8'($urandom), 8, bl, 0, rp);
                  queue_ticks(LINE_LOW, bl, rp);
                  queue_ticks(LINE_HIGH, 2 * bl, rp);
               end
            end
            wait_until_drained();
         end
      end

      wait_until_drained();
      repeat (SETTLE) @(posedge clock);
      if (error_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/urx_pkg.sv
hw/rtl/urx_front.sv
hw/rtl/urx_queue.sv
hw/rtl/urx_back.sv
hw/rtl/uart_receiver.sv
hw/rtl/urx_checker.sv
bench/tb.sv
